// ===== hw/rtl/jeu_pkg.sv =====
// ----------------------------------------------------------------------------
// jeu_pkg
// Types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jeu_pkg;

   localparam int unsigned MAX_RESULTS = 6;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   // result error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_ESC   = 2'd1;
   localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
   localparam logic [1:0] ERR_TRAIL_ESC = 2'd3;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [15:0] SURR_HI_LO = 16'hD800;
   localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
   localparam logic [15:0] SURR_LO_LO = 16'hDC00;
   localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [20:0] REPL_CHAR  = 21'h0FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } jeu_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] error;
      logic       last_of_run;
      logic       end_of_string;
   } jeu_rsp_type;

   // one buffered result before the run flags are attached
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] error;
   } jeu_item_type;

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_ESC        = 6'b000010,
      PH_HEX        = 6'b000100,
      PH_AFTER_HIGH = 6'b001000,
      PH_HIGH_ESC   = 6'b010000,
      PH_LOW_HEX    = 6'b100000
   } jeu_phase_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } jeu_utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } jeu_hex_type;

   typedef struct packed {
      logic       ok;
      logic       is_u;
      logic [7:0] value;
   } jeu_esc_type;

   function automatic jeu_utf8_type utf8_encode(input logic [20:0] cp);
      jeu_utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.len = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.len = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.len = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.len = 3'd4;
      end
      return r;
   endfunction

   function automatic jeu_hex_type hex_decode(input logic [7:0] b);
      jeu_hex_type r;
      r.ok = 1'b1;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.value = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
         r.value = '0;
      end
      return r;
   endfunction

   function automatic jeu_esc_type esc_decode(input logic [7:0] b);
      jeu_esc_type r;
      r.ok = 1'b1;
      r.is_u = 1'b0;
      r.value = b;
      unique case (b)
         8'h22, 8'h5C, 8'h2F: r.value = b;
         8'h6E: r.value = 8'h0A;
         8'h74: r.value = 8'h09;
         8'h72: r.value = 8'h0D;
         8'h62: r.value = 8'h08;
         8'h66: r.value = 8'h0C;
         8'h75: r.is_u = 1'b1;
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jeu_if.sv =====
// ----------------------------------------------------------------------------
// jeu_req_if / jeu_rsp_if
// Valid/ready channels carrying raw input bytes and decoded result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jeu_req_if;
   logic                valid;
   logic                ready;
   jeu_pkg::jeu_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface jeu_rsp_if;
   logic                valid;
   logic                ready;
   jeu_pkg::jeu_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/json_escape_to_utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// json_escape_to_utf8_decoder
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Accepts one raw string-body byte per beat and emits 0 to 6 result bytes.
// Each accepted byte is decoded combinationally against the escape state and
// its results go to a 6-entry result buffer that drains one beat per cycle
// while the output is ready. A new byte is taken in the same cycle that the
// last buffered result of the previous byte leaves, so bytes giving at most
// one result flow at one per cycle under that condition; a byte giving more
// holds off the input until its results drain through the single-beat port.
// Results appear in the cycle after their input byte is accepted. After an
// error result the rest of the string is dropped up to the byte with string_end.
`default_nettype none

module json_escape_to_utf8_decoder (
   input  wire         clock,
   input  wire         reset,
   jeu_req_if.sink     req_chan,
   jeu_rsp_if.source   rsp_chan
);
   import jeu_pkg::*;

   jeu_phase_type phase_ff, phase_in;
   logic [1:0]    hex_count_ff, hex_count_in;
   logic [15:0]   code_unit_ff, code_unit_in;
   logic [9:0]    high_half_ff, high_half_in;
   logic          discarding_ff, discarding_in;

   jeu_item_type  items_ff [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff;
   logic          eos_ff;

   logic          accept, pop;
   logic [7:0]    b;
   logic          str_end;

   // decode results
   jeu_item_type  tmp [8];
   logic [2:0]    n;
   logic [1:0]    err;
   logic          pre_fffd, do_cp, do_byte, end_fffd;
   logic [20:0]   cp_val;
   logic [7:0]    byte_val;
   jeu_hex_type   hx;
   jeu_esc_type   ex;
   jeu_utf8_type  enc_cp, enc_repl;
   logic [15:0]   cu_next;
   jeu_phase_type ph_mid;

   assign b       = req_chan.payload.in_byte;
   assign str_end = req_chan.payload.string_end;
   assign hx      = hex_decode(b);
   assign ex      = esc_decode(b);
   assign cu_next = {code_unit_ff[11:0], hx.value};
   assign enc_cp   = utf8_encode(cp_val);
   assign enc_repl = utf8_encode(REPL_CHAR);

   assign rsp_chan.valid = (cnt_ff != '0);
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.payload.out_byte      = items_ff[0].out_byte;
   assign rsp_chan.payload.error         = items_ff[0].error;
   assign rsp_chan.payload.last_of_run   = (cnt_ff == CNT_W'(1));
   assign rsp_chan.payload.end_of_string = (cnt_ff == CNT_W'(1)) && eos_ff;

   // next escape state and result segments for the byte on the input
   always_comb begin
      phase_in      = phase_ff;
      hex_count_in  = hex_count_ff;
      code_unit_in  = code_unit_ff;
      high_half_in  = high_half_ff;
      discarding_in = discarding_ff;
      err      = ERR_NONE;
      pre_fffd = 1'b0;
      do_cp    = 1'b0;
      do_byte  = 1'b0;
      end_fffd = 1'b0;
      cp_val   = '0;
      byte_val = b;

      if (!discarding_ff) begin
         unique case (phase_ff)
            PH_ESC: begin
               if (ex.is_u) begin
                  phase_in = PH_HEX;
                  hex_count_in = '0;
                  code_unit_in = '0;
               end else if (ex.ok) begin
                  do_byte = 1'b1;
                  byte_val = ex.value;
                  phase_in = PH_IDLE;
               end else begin
                  err = ERR_BAD_ESC;
               end
            end
            PH_HEX, PH_LOW_HEX: begin
               if (!hx.ok) begin
                  err = ERR_BAD_HEX;
               end else begin
                  code_unit_in = cu_next;
                  if (hex_count_ff != 2'd3) begin
                     hex_count_in = hex_count_ff + 2'd1;
                  end else begin
                     hex_count_in = '0;
                     if (phase_ff == PH_LOW_HEX && cu_next >= SURR_LO_LO
                         && cu_next <= SURR_LO_HI) begin
                        // joined pair, low unit offset is its ten low bits
                        do_cp = 1'b1;
                        cp_val = SUPP_BASE + {1'b0, high_half_ff, cu_next[9:0]};
                        phase_in = PH_IDLE;
                     end else begin
                        pre_fffd = (phase_ff == PH_LOW_HEX);
                        if (cu_next >= SURR_HI_LO && cu_next <= SURR_HI_HI) begin
                           high_half_in = cu_next[9:0];
                           phase_in = PH_AFTER_HIGH;
                        end else begin
                           do_cp = 1'b1;
                           if (cu_next >= SURR_LO_LO && cu_next <= SURR_LO_HI) begin
                              cp_val = REPL_CHAR;
                           end else begin
                              cp_val = {5'd0, cu_next};
                           end
                           phase_in = PH_IDLE;
                        end
                     end
                  end
               end
            end
            PH_AFTER_HIGH: begin
               if (b == CH_BSLASH) begin
                  phase_in = PH_HIGH_ESC;
               end else begin
                  pre_fffd = 1'b1;
                  do_byte = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_HIGH_ESC: begin
               if (b == CH_U) begin
                  phase_in = PH_LOW_HEX;
                  hex_count_in = '0;
                  code_unit_in = '0;
               end else begin
                  pre_fffd = 1'b1;
                  if (ex.ok) begin
                     do_byte = 1'b1;
                     byte_val = ex.value;
                     phase_in = PH_IDLE;
                  end else begin
                     err = ERR_BAD_ESC;
                  end
               end
            end
            default: begin
               if (b == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  do_byte = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         endcase

         ph_mid = phase_in;
         if (err == ERR_NONE && str_end) begin
            priority case (1'b1)
               ph_mid == PH_ESC: err = ERR_TRAIL_ESC;
               ph_mid == PH_HEX || ph_mid == PH_LOW_HEX: err = ERR_BAD_HEX;
               ph_mid == PH_AFTER_HIGH: end_fffd = 1'b1;
               ph_mid == PH_HIGH_ESC: begin
                  end_fffd = 1'b1;
                  err = ERR_TRAIL_ESC;
               end
               default: ;
            endcase
         end

         if (err != ERR_NONE || str_end) begin
            phase_in     = PH_IDLE;
            hex_count_in = '0;
            code_unit_in = '0;
            high_half_in = '0;
         end
         if (err != ERR_NONE) begin
            discarding_in = !str_end;
         end
      end else begin
         ph_mid = phase_ff;
         if (str_end) begin
            discarding_in = 1'b0;
         end
      end
   end

   // pack the segments into the result list in order
   always_comb begin
      n = '0;
      for (int i = 0; i < 8; i++) begin
         tmp[i] = '0;
      end
      if (pre_fffd) begin
         for (int k = 0; k < 3; k++) begin
            tmp[n] = '{out_byte: enc_repl.bytes[k], error: ERR_NONE};
            n = n + 3'd1;
         end
      end
      if (do_cp) begin
         for (int k = 0; k < 4; k++) begin
            if (3'(k) < enc_cp.len) begin
               tmp[n] = '{out_byte: enc_cp.bytes[k], error: ERR_NONE};
               n = n + 3'd1;
            end
         end
      end
      if (do_byte) begin
         tmp[n] = '{out_byte: byte_val, error: ERR_NONE};
         n = n + 3'd1;
      end
      if (end_fffd) begin
         for (int k = 0; k < 3; k++) begin
            tmp[n] = '{out_byte: enc_repl.bytes[k], error: ERR_NONE};
            n = n + 3'd1;
         end
      end
      if (err != ERR_NONE) begin
         tmp[n] = '{out_byte: 8'h00, error: err};
         n = n + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hex_count_ff  <= '0;
         code_unit_ff  <= '0;
         high_half_ff  <= '0;
         discarding_ff <= 1'b0;
         cnt_ff        <= '0;
         eos_ff        <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hex_count_ff  <= hex_count_in;
         code_unit_ff  <= code_unit_in;
         high_half_ff  <= high_half_in;
         discarding_ff <= discarding_in;
         cnt_ff        <= CNT_W'(n);
         eos_ff        <= (err != ERR_NONE) || str_end;
      end else if (pop) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // result buffer: loads on accept, shifts down one entry per beat
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            items_ff[i] <= tmp[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            items_ff[i] <= items_ff[i+1];
         end
      end
   end

endmodule

`default_nettype wire
